// ===== src/aes_cbc_pkg.sv =====
`default_nettype none
package aes_cbc_pkg;

  localparam int BlockW   = 128;
  localparam int WordW    = 64;
  localparam int RkRows   = 15;                 // round keys for 14 rounds plus the initial one
  localparam int RkAddrW  = $clog2(RkRows);
  localparam int WordIdxW = 6;                  // up to 60 expanded 32-bit words

  typedef enum logic [2:0] {
    REG_DECRYPT_MODE = 3'd0,
    REG_KEY_LENGTH   = 3'd1,
    REG_KEY_BITS_0   = 3'd2,
    REG_KEY_BITS_1   = 3'd3,
    REG_KEY_BITS_2   = 3'd4,
    REG_KEY_BITS_3   = 3'd5,
    REG_IV_HIGH      = 3'd6,
    REG_IV_LOW       = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2
  } key_len_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPAND,
    S_KEY0,
    S_ROUND,
    S_OUT
  } state_t;

  localparam logic [7:0] SBOX_FWD [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] SBOX_INV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
  endfunction

  // byte k of a block sits at bits [127-8k -: 8]
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int k = 0; k < 16; k++) begin
      o[127-8*k -: 8] = inv ? SBOX_INV[s[127-8*k -: 8]] : SBOX_FWD[s[127-8*k -: 8]];
    end
    return o;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    int src;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
        o[127-8*(c*4+r) -: 8] = s[127-8*(src*4+r) -: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m [4];
    logic [7:0] acc;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = s[127-8*(c*4+k) -: 8];
        x2[k] = xtime(a[k]);
        x4[k] = xtime(x2[k]);
        x8[k] = xtime(x4[k]);
      end
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          // coefficient row: fwd {2,3,1,1}, inverse {e,b,d,9}
          case ((k + 4 - r) & 3)
            0:       m[k] = inv ? (x8[k] ^ x4[k] ^ x2[k]) : x2[k];
            1:       m[k] = inv ? (x8[k] ^ x2[k] ^ a[k])  : (x2[k] ^ a[k]);
            2:       m[k] = inv ? (x8[k] ^ x4[k] ^ a[k])  : a[k];
            default: m[k] = inv ? (x8[k] ^ a[k])          : a[k];
          endcase
          acc = acc ^ m[k];
        end
        o[127-8*(c*4+r) -: 8] = acc;
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== src/aes_cbc_block_cipher.sv =====
// channel  | dir | tdata (low bit up)                  | tuser
// s_axis   | in  | block_high[63:0], block_low[127:64] | first_block
// m_axis   | out | result_high[63:0], result_low[127:64] | -
// cfg      | in  | cfg_index selects register, cfg_data[63:0] | -
//
// A block runs S_KEY0, S_ROUND (key addition, then 10/12/14 rounds for
// 128/192/256-bit keys) and S_OUT; a first block expands 44/52/60 key words
// in S_EXPAND first, one 32-bit word per cycle. One round per cycle through
// a shared round unit, round keys read from a 15-row RAM one row ahead. rst
// is synchronous and clears control and configuration. A stalled result waits
// in the output register and the core holds in S_OUT until it can be loaded.
`default_nettype none
module aes_cbc_block_cipher
  import aes_cbc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // block_high, block_low
  input  wire logic         s_axis_tuser,   // first_block
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata,   // result_high, result_low
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  logic              decrypt_mode;
  logic [1:0]        key_length_select;
  logic [WordW-1:0]  key_bits [4];
  logic [WordW-1:0]  iv_high, iv_low;

  state_t            state, state_next;
  logic [BlockW-1:0] st;
  logic [BlockW-1:0] in_data;
  logic [BlockW-1:0] in_block;
  logic [BlockW-1:0] chain;
  logic [3:0]        rnd;
  logic [WordIdxW-1:0] widx;
  logic [2:0]        kmod;
  logic [7:0]        rc;
  logic [31:0]       win [8];
  logic [95:0]       row_buf;

  logic [3:0]        nk, nr;
  logic [WordIdxW-1:0] total;
  logic [31:0]       new_word, tword, key_word, old_word;
  logic              ram_we;
  logic [RkAddrW-1:0] rd_addr;
  logic [BlockW-1:0] rkey;
  logic [BlockW-1:0] round_out;
  logic [BlockW-1:0] result;
  logic              in_acc, out_load, exp_last;

  // internal block order: byte 0 in the top bits, block_high first
  assign in_data = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

  always_comb begin
    unique case (key_length_select)
      KEY_192: nk = 4'd6;
      KEY_256: nk = 4'd8;
      default: nk = 4'd4;
    endcase
    nr    = nk + 4'd6;
    total = WordIdxW'({nk + 4'd7, 2'b00});
  end

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);
  assign exp_last = (widx == total - WordIdxW'(1));

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode      <= 1'b0;
      key_length_select <= '0;
      for (int i = 0; i < 4; i++) key_bits[i] <= '0;
      iv_high           <= '0;
      iv_low            <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DECRYPT_MODE: decrypt_mode      <= cfg_data[0];
        REG_KEY_LENGTH:   key_length_select <= cfg_data[1:0];
        REG_KEY_BITS_0:   key_bits[0]       <= cfg_data;
        REG_KEY_BITS_1:   key_bits[1]       <= cfg_data;
        REG_KEY_BITS_2:   key_bits[2]       <= cfg_data;
        REG_KEY_BITS_3:   key_bits[3]       <= cfg_data;
        REG_IV_HIGH:      iv_high           <= cfg_data;
        REG_IV_LOW:       iv_low            <= cfg_data;
        default: ;
      endcase
    end
  end

  // key expansion word
  always_comb begin
    key_word = widx[0] ? key_bits[widx[2:1]][31:0] : key_bits[widx[2:1]][63:32];
    unique case (nk)
      4'd6:    old_word = win[5];
      4'd8:    old_word = win[7];
      default: old_word = win[3];
    endcase
    tword = win[0];
    if (kmod == 3'd0) begin
      tword = sub_word({win[0][23:0], win[0][31:24]}) ^ {rc, 24'h0};
    end else if (nk == 4'd8 && kmod == 3'd4) begin
      tword = sub_word(win[0]);
    end
    new_word = (widx < WordIdxW'(nk)) ? key_word : (old_word ^ tword);
  end

  // round unit
  always_comb begin
    if (rnd == 4'd0) begin
      round_out = st ^ rkey;
    end else if (!decrypt_mode) begin
      if (rnd == nr) round_out = shift_rows(sub_bytes(st, 1'b0), 1'b0) ^ rkey;
      else round_out = mix_columns(shift_rows(sub_bytes(st, 1'b0), 1'b0), 1'b0) ^ rkey;
    end else begin
      if (rnd == nr) round_out = sub_bytes(shift_rows(st, 1'b1), 1'b1) ^ rkey;
      else round_out = mix_columns(sub_bytes(shift_rows(st, 1'b1), 1'b1) ^ rkey, 1'b1);
    end
    result = decrypt_mode ? (st ^ chain) : st;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_acc) state_next = s_axis_tuser ? S_EXPAND : S_KEY0;
      S_EXPAND: if (exp_last) state_next = S_KEY0;
      S_KEY0:   state_next = S_ROUND;
      S_ROUND:  if (rnd == nr) state_next = S_OUT;
      S_OUT:    if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    rd_addr       = '0;
    unique case (state)
      S_IDLE:   s_axis_tready = 1'b1;
      S_EXPAND: ram_we = (widx[1:0] == 2'b11);
      S_KEY0:   rd_addr = decrypt_mode ? RkAddrW'(nr) : '0;
      S_ROUND:  rd_addr = decrypt_mode ? RkAddrW'(nr - rnd - 4'd1) : RkAddrW'(rnd + 4'd1);
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      chain         <= '0;
    end else begin
      state <= state_next;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (in_acc && s_axis_tuser) chain <= {iv_high, iv_low};
      if (out_load) chain <= decrypt_mode ? in_block : st;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_block <= in_data;
      widx     <= '0;
      kmod     <= '0;
      rc       <= 8'h01;
      if (decrypt_mode) begin
        st <= in_data;
      end else if (s_axis_tuser) begin
        st <= in_data ^ {iv_high, iv_low};
      end else begin
        st <= in_data ^ chain;
      end
    end
    if (state == S_EXPAND) begin
      widx    <= widx + WordIdxW'(1);
      kmod    <= (kmod == 3'(nk - 4'd1)) ? 3'd0 : kmod + 3'd1;
      if (kmod == 3'd0 && widx >= WordIdxW'(nk)) rc <= xtime(rc);
      row_buf <= {row_buf[63:0], new_word};
      win[0]  <= new_word;
      for (int i = 1; i < 8; i++) win[i] <= win[i-1];
    end
    if (state == S_KEY0) rnd <= '0;
    if (state == S_ROUND) begin
      st  <= round_out;
      rnd <= rnd + 4'd1;
    end
    // result_high goes to the low half of tdata
    if (out_load) m_axis_tdata <= {result[63:0], result[127:64]};
  end

  aes_cbc_ram #(
    .Width (BlockW),
    .Depth (RkRows)
  ) u_rk_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (widx[RkAddrW+1:2]),
    .wr_data ({row_buf, new_word}),
    .rd_addr (rd_addr),
    .rd_data (rkey)
  );

endmodule
`default_nettype wire

// ===== src/aes_cbc_ram.sv =====
`default_nettype none
module aes_cbc_ram #(
  parameter int Width = 128,
  parameter int Depth = 15
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/aes_cbc_checker.sv =====
`default_nettype none
module aes_cbc_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [127:0] m_axis_tdata
);

  // core is busy after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken back to back");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result one cycle after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind aes_cbc_block_cipher aes_cbc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== test/tb_aes_cbc_block_cipher.sv =====
`timescale 1ns / 1ps
module tb_aes_cbc_block_cipher;
  import aes_cbc_pkg::*;

  localparam int MAX_CYCLES = 400000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // block_high, block_low
  logic         s_axis_tuser;   // first_block
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // result_high, result_low
  logic         cfg_wr_en;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;

  aes_cbc_block_cipher uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // S-box tables generated locally from GF(2^8) inverse plus affine map
  logic [7:0] fwd_box [256];
  logic [7:0] inv_box [256];

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = gf_dbl(a);
    end
    return r;
  endfunction

  task automatic build_boxes();
    logic [7:0] v, q, s;
    for (int x = 0; x < 256; x++) begin
      v = 0;
      for (int y = 1; y < 256; y++)
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) v = y[7:0];
      q = v;
      s = v ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]}
          ^ 8'h63;
      fwd_box[x] = s;
      inv_box[s] = x[7:0];
    end
  endtask

  class cbc_scoreboard;
    bit          decrypting;
    logic [1:0]  key_len;
    logic [63:0] key_reg [4];
    logic [63:0] iv_reg [2];
    logic [31:0] sched [60];
    logic [127:0] chain;
    logic [127:0] pending [$];
    int          errors;

    function void write_reg(cfg_reg_t idx, logic [63:0] val);
      case (idx)
        REG_DECRYPT_MODE: decrypting = val[0];
        REG_KEY_LENGTH:   key_len = val[1:0];
        REG_KEY_BITS_0:   key_reg[0] = val;
        REG_KEY_BITS_1:   key_reg[1] = val;
        REG_KEY_BITS_2:   key_reg[2] = val;
        REG_KEY_BITS_3:   key_reg[3] = val;
        REG_IV_HIGH:      iv_reg[0] = val;
        REG_IV_LOW:       iv_reg[1] = val;
        default: ;
      endcase
    endfunction

    function int nk();
      if (key_len == KEY_192) return 6;
      if (key_len == KEY_256) return 8;
      return 4;
    endfunction

    function logic [31:0] subw(logic [31:0] t);
      return {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
    endfunction

    function void expand();
      int n;
      logic [7:0] rc;
      logic [31:0] t;
      n = nk();
      rc = 8'h01;
      for (int i = 0; i < 4 * (n + 7); i++) begin
        if (i < n) begin
          sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
        end else begin
          t = sched[i-1];
          if (i % n == 0) begin
            t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gf_dbl(rc);
          end else if (n > 6 && i % n == 4) begin
            t = subw(t);
          end
          sched[i] = sched[i-n] ^ t;
        end
      end
    endfunction

    function logic [127:0] rk(int r);
      return {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
    endfunction

    function logic [127:0] sbytes(logic [127:0] s, bit inv);
      for (int k = 0; k < 16; k++)
        s[127-8*k -: 8] = inv ? inv_box[s[127-8*k -: 8]] : fwd_box[s[127-8*k -: 8]];
      return s;
    endfunction

    function logic [127:0] srows(logic [127:0] s, bit inv);
      logic [127:0] o;
      int src;
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) begin
          src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
          o[127-8*(c*4+r) -: 8] = s[127-8*(src*4+r) -: 8];
        end
      return o;
    endfunction

    function logic [127:0] mcols(logic [127:0] s, bit inv);
      logic [127:0] o;
      logic [7:0] coef [4];
      logic [7:0] acc;
      if (inv) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) begin
          acc = 0;
          for (int k = 0; k < 4; k++)
            acc ^= gf_mul(s[127-8*(c*4+k) -: 8], coef[(k + 4 - r) & 3]);
          o[127-8*(c*4+r) -: 8] = acc;
        end
      return o;
    endfunction

    function void note_block(logic [127:0] blk, bit first);
      int nr;
      logic [127:0] s;
      nr = nk() + 6;
      if (first) begin
        expand();
        chain = {iv_reg[0], iv_reg[1]};
      end
      if (!decrypting) begin
        s = (blk ^ chain) ^ rk(0);
        for (int r = 1; r < nr; r++) s = mcols(srows(sbytes(s, 0), 0), 0) ^ rk(r);
        s = srows(sbytes(s, 0), 0) ^ rk(nr);
        chain = s;
      end else begin
        s = blk ^ rk(nr);
        for (int r = nr - 1; r >= 1; r--) s = mcols(sbytes(srows(s, 1), 1) ^ rk(r), 1);
        s = sbytes(srows(s, 1), 1) ^ rk(0) ^ chain;
        chain = blk;
      end
      pending = {pending, s};
    endfunction

    function void check_result(logic [127:0] got);
      logic [127:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got[127:64] !== want[127:64]) begin
        $display("%0t: result_high expected %h actual %h", $time, want[127:64], got[127:64]);
        errors++;
      end
      if (got[63:0] !== want[63:0]) begin
        $display("%0t: result_low expected %h actual %h", $time, want[63:0], got[63:0]);
        errors++;
      end
    endfunction
  endclass

  cbc_scoreboard cipher_sb;
  int  cycles;
  bit  calm;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // tdata: block_high in the low 64 bits; byte order maps to model's hi/lo
  function automatic logic [127:0] to_model(logic [127:0] d);
    return {d[63:0], d[127:64]};
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) cipher_sb.check_result(to_model(m_axis_tdata));
  end

  // output-side stall bursts
  initial begin
    m_axis_tready = 0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic write_cfg(cfg_reg_t idx, logic [63:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    cipher_sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_block(logic [63:0] hi, logic [63:0] lo, bit first);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {lo, hi};
    s_axis_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    cipher_sb.note_block({hi, lo}, first);
    s_axis_tvalid <= 0;
    // core is busy after a transaction, so this gap costs nothing
    @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (cipher_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge64();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return '1;
      default: return rnd64();
    endcase
  endfunction

  task automatic load_setup(bit dec, logic [1:0] klen, bit extremes);
    write_cfg(REG_DECRYPT_MODE, {63'h0, dec});
    write_cfg(REG_KEY_LENGTH, {62'h0, klen});
    write_cfg(REG_KEY_BITS_0, extremes ? edge64() : rnd64());
    write_cfg(REG_KEY_BITS_1, extremes ? edge64() : rnd64());
    write_cfg(REG_KEY_BITS_2, extremes ? edge64() : rnd64());
    write_cfg(REG_KEY_BITS_3, extremes ? edge64() : rnd64());
    write_cfg(REG_IV_HIGH, extremes ? edge64() : rnd64());
    write_cfg(REG_IV_LOW, extremes ? edge64() : rnd64());
  endtask

  initial begin
    int sent;
    int run;
    build_boxes();
    cipher_sb = new();
    calm = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    cfg_wr_en = 0;
    cfg_index = REG_DECRYPT_MODE;
    cfg_data = 0;
    cipher_sb.write_reg(REG_DECRYPT_MODE, 64'h0);
    cipher_sb.write_reg(REG_KEY_LENGTH, 64'h0);
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // FIPS-197 appendix C vectors (128/192/256-bit keys), zero IV: plain AES
    write_cfg(REG_KEY_BITS_0, 64'h0001020304050607);
    write_cfg(REG_KEY_BITS_1, 64'h08090a0b0c0d0e0f);
    write_cfg(REG_KEY_BITS_2, 64'h1011121314151617);
    write_cfg(REG_KEY_BITS_3, 64'h18191a1b1c1d1e1f);
    write_cfg(REG_IV_HIGH, 64'h0);
    write_cfg(REG_IV_LOW, 64'h0);
    for (int m = 0; m < 8; m++) begin
      write_cfg(REG_DECRYPT_MODE, {63'h0, m[0]});
      // code 3 is unused and behaves like a 128-bit key
      write_cfg(REG_KEY_LENGTH, {62'h0, m[2:1]});
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1);
      send_block(64'h0, 64'h0, 0);
      send_block('1, '1, 0);
      drain();
    end

    // key registers changed after expansion only matter at the next first block
    write_cfg(REG_KEY_BITS_0, '1);
    send_block(rnd64(), rnd64(), 0);
    drain();

    sent = 0;
    while (sent < 800) begin
      load_setup(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)));
      run = $urandom_range(1, 12);
      for (int i = 0; i < run; i++) begin
        if (sent > 700) calm = 1;
        send_block(edge64(), edge64(), i == 0 || $urandom_range(0, 9) == 0);
        sent++;
      end
      drain();
    end

    if (cipher_sb.errors == 0 && cipher_sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
